// ===== src/rrrl_pkg.sv =====
`default_nettype none

package rrrl_pkg;

  localparam int unsigned RingCapacity = 16;

  localparam int unsigned IdW    = 16;
  localparam int unsigned TotalW = 5;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpRotate = 2'd2,
    OpQuery  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== src/rrrl_ram.sv =====
`default_nettype none

module rrrl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/round_robin_ring_list_unit.sv =====
`default_nettype none

// Round-robin ring of member ids kept as a circular singly linked list in two
// single-port-write RAMs (id store and link store), with head, tail, count,
// free map and id counter in flip-flops. One command at a time: start is
// taken while busy is low, and the result appears on the result ports for
// exactly one cycle with done high; it is not held, so the receiver must
// take it then. Query and error answers go from the start transfer straight
// to the done cycle; rotate, add and remove end with a head read. Add first
// scans for a free slot (one slot per cycle, lowest first) and links it;
// remove walks from the head (one id and link read per cycle, at most the
// member count). Busy stays high through the done cycle.
module round_robin_ring_list_unit #(
  parameter int unsigned RING_CAPACITY = rrrl_pkg::RingCapacity
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [rrrl_pkg::IdW-1:0]    target_id_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [rrrl_pkg::IdW-1:0]         result_id_o,
  output logic [rrrl_pkg::IdW-1:0]         on_duty_id_o,
  output logic [rrrl_pkg::TotalW-1:0]      member_total_o
);

  import rrrl_pkg::*;

  localparam int unsigned SW = $clog2(RING_CAPACITY);
  localparam int unsigned CW = $clog2(RING_CAPACITY + 1);

  typedef enum logic [6:0] {
    SIdle    = 7'b0000001,
    SAddScan = 7'b0000010,
    SAddLink = 7'b0000100,
    SRotate  = 7'b0001000,
    SRmChk   = 7'b0010000,
    SHeadRd  = 7'b0100000,
    SEmit    = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [SW-1:0]          head_q, head_d;
  logic [SW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          count_q, count_d;
  logic [RING_CAPACITY-1:0] free_q, free_d;
  logic [IdW-1:0]         ctr_q, ctr_d;
  logic [SW-1:0]          scan_q, scan_d;
  logic [SW-1:0]          cur_q, cur_d;
  logic [SW-1:0]          prev_q, prev_d;
  logic [CW-1:0]          n_q, n_d;
  logic [IdW-1:0]         target_q, target_d;
  logic [IdW-1:0]         result_q, result_d;
  status_e                status_q, status_d;
  logic                   use_head_q, use_head_d;

  logic                   id_we;
  logic [IdW-1:0]         id_rdata;
  logic                   link_we;
  logic [SW-1:0]          link_waddr;
  logic [SW-1:0]          link_wdata;
  logic [SW-1:0]          link_rdata;
  logic [SW-1:0]          raddr;
  logic [CW+TotalW-1:0]   total_ext;

  rrrl_ram #(
    .Width (IdW),
    .Depth (RING_CAPACITY)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (scan_q),
    .wdata_i (ctr_q),
    .raddr_i (raddr),
    .rdata_o (id_rdata)
  );

  rrrl_ram #(
    .Width (SW),
    .Depth (RING_CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rdata)
  );

  // the walk follows the link just read, everything else reads the head
  assign raddr = (state_q == SRmChk) ? link_rdata : head_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    free_d     = free_q;
    ctr_d      = ctr_q;
    scan_d     = scan_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    n_d        = n_q;
    target_d   = target_q;
    result_d   = result_q;
    status_d   = status_q;
    use_head_d = use_head_q;
    id_we      = 1'b0;
    link_we    = 1'b0;
    link_waddr = scan_q;
    link_wdata = scan_q;

    case (state_q)
      SIdle: begin
        if (start_i) begin
          target_d   = target_id_i;
          result_d   = '0;
          status_d   = StOk;
          use_head_d = 1'b0;
          cur_d      = head_q;
          prev_d     = tail_q;
          n_d        = '0;
          scan_d     = '0;
          if (op_e'(operation_i) == OpAdd) begin
            if (count_q >= CW'(RING_CAPACITY)) begin
              status_d = StFull;
              state_d  = SEmit;
            end else begin
              state_d = SAddScan;
            end
          end else if (count_q == '0) begin
            status_d = StEmpty;
            state_d  = SEmit;
          end else begin
            case (op_e'(operation_i))
              OpRemove: state_d = SRmChk;
              OpRotate: begin
                use_head_d = 1'b1;
                state_d    = SRotate;
              end
              default: begin
                use_head_d = 1'b1;
                state_d    = SEmit;
              end
            endcase
          end
        end
      end

      SAddScan: begin
        if (free_q[scan_q]) begin
          id_we      = 1'b1;
          link_we    = 1'b1;
          link_waddr = scan_q;
          link_wdata = (count_q == '0) ? scan_q : head_q;
          state_d    = SAddLink;
        end else begin
          scan_d = scan_q + SW'(1);
        end
      end

      SAddLink: begin
        if (count_q == '0) begin
          head_d = scan_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = tail_q;
          link_wdata = scan_q;
        end
        tail_d         = scan_q;
        count_d        = count_q + CW'(1);
        free_d[scan_q] = 1'b0;
        result_d       = ctr_q;
        ctr_d          = (ctr_q == '1) ? IdW'(1) : ctr_q + IdW'(1);
        state_d        = SHeadRd;
      end

      SRotate: begin
        tail_d  = head_q;
        head_d  = link_rdata;
        state_d = SHeadRd;
      end

      SRmChk: begin
        if (id_rdata == target_q) begin
          if (count_q == CW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q;
            link_wdata = link_rdata;
            if (cur_q == head_q) begin
              head_d = link_rdata;
            end
            if (cur_q == tail_q) begin
              tail_d = prev_q;
            end
          end
          free_d[cur_q] = 1'b1;
          count_d       = count_q - CW'(1);
          result_d      = target_q;
          state_d       = SHeadRd;
        end else if (n_q == count_q - CW'(1)) begin
          status_d = StNotFound;
          state_d  = SHeadRd;
        end else begin
          n_d    = n_q + CW'(1);
          prev_d = cur_q;
          cur_d  = link_rdata;
        end
      end

      SHeadRd: state_d = SEmit;

      SEmit: state_d = SIdle;

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      free_q     <= '1;
      ctr_q      <= IdW'(1);
      scan_q     <= '0;
      cur_q      <= '0;
      prev_q     <= '0;
      n_q        <= '0;
      status_q   <= StOk;
      use_head_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      free_q     <= free_d;
      ctr_q      <= ctr_d;
      scan_q     <= scan_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      n_q        <= n_d;
      status_q   <= status_d;
      use_head_q <= use_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    result_q <= result_d;
  end

  assign total_ext = {{TotalW{1'b0}}, count_q};

  assign busy_o         = (state_q != SIdle);
  assign done_o         = (state_q == SEmit);
  assign status_o       = status_q;
  assign result_id_o    = use_head_q ? id_rdata : result_q;
  assign on_duty_id_o   = (count_q != '0) ? id_rdata : '0;
  assign member_total_o = total_ext[TotalW-1:0];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrrl_pkg::*;

  localparam int unsigned Slots      = RingCapacity;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned MaxPrinted = 20;

  typedef struct packed {
    status_e             status;
    logic [IdW-1:0]      result_id;
    logic [IdW-1:0]      on_duty_id;
    logic [TotalW-1:0]   member_total;
  } ring_answer_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [1:0]        operation_i = '0;
  logic [IdW-1:0]    target_id_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [IdW-1:0]    result_id_o;
  logic [IdW-1:0]    on_duty_id_o;
  logic [TotalW-1:0] member_total_o;

  round_robin_ring_list_unit #(
    .RING_CAPACITY(Slots)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .target_id_i   (target_id_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .on_duty_id_o  (on_duty_id_o),
    .member_total_o(member_total_o)
  );

  // predicted ring
  logic [IdW-1:0]   ring_id   [Slots];
  logic [SlotW-1:0] ring_link [Slots];
  logic [SlotW-1:0] ring_head;
  logic [SlotW-1:0] ring_tail;
  int unsigned      ring_count;
  logic [Slots-1:0] ring_free;
  logic [IdW-1:0]   ring_next_id;

  ring_answer_t pending_answers[$];

  int unsigned mismatch_count = 0;
  int unsigned op_seen[4]     = '{default: 0};
  int unsigned status_seen[4] = '{default: 0};
  int unsigned wrap_count     = 0;
  bit          calm_sender    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("** round_robin_ring_list_unit: FAILED **");
    $finish;
  end

  task automatic ring_reset();
    int i;
    for (i = 0; i < Slots; i++) begin
      ring_id[i]   = '0;
      ring_link[i] = '0;
    end
    ring_head    = '0;
    ring_tail    = '0;
    ring_count   = 0;
    ring_free    = '1;
    ring_next_id = 16'd1;
  endtask

  function automatic ring_answer_t ring_apply(op_e op, logic [IdW-1:0] tgt);
    ring_answer_t     ans;
    int               i;
    bit               found;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] prev;
    ans.status    = StOk;
    ans.result_id = '0;
    found         = 1'b0;
    slot          = '0;
    if (op == OpAdd) begin
      for (i = Slots - 1; i >= 0; i--) begin
        if (ring_free[i]) begin
          found = 1'b1;
          slot  = SlotW'(i);
        end
      end
      if (!found || ring_count >= Slots) begin
        ans.status = StFull;
      end else begin
        ans.result_id = ring_next_id;
        ring_id[slot] = ring_next_id;
        if (ring_next_id == '1) begin
          ring_next_id = 16'd1;
          wrap_count++;
        end else begin
          ring_next_id = ring_next_id + 16'd1;
        end
        ring_free[slot] = 1'b0;
        if (ring_count == 0) begin
          ring_head       = slot;
          ring_tail       = slot;
          ring_link[slot] = slot;
        end else begin
          ring_link[ring_tail] = slot;
          ring_link[slot]      = ring_head;
          ring_tail            = slot;
        end
        ring_count++;
      end
    end else if (ring_count == 0) begin
      ans.status = StEmpty;
    end else if (op == OpRemove) begin
      prev = ring_tail;
      slot = ring_head;
      for (i = 0; i < ring_count && !found; i++) begin
        if (ring_id[slot] == tgt) begin
          found = 1'b1;
        end else begin
          prev = slot;
          slot = ring_link[slot];
        end
      end
      if (!found) begin
        ans.status = StNotFound;
      end else begin
        if (ring_count == 1) begin
          ring_head = '0;
          ring_tail = '0;
        end else begin
          ring_link[prev] = ring_link[slot];
          if (slot == ring_head) ring_head = ring_link[slot];
          if (slot == ring_tail) ring_tail = prev;
        end
        ring_free[slot] = 1'b1;
        ring_count--;
        ans.result_id = tgt;
      end
    end else if (op == OpRotate) begin
      ring_tail     = ring_head;
      ring_head     = ring_link[ring_tail];
      ans.result_id = ring_id[ring_head];
    end else begin
      ans.result_id = ring_id[ring_head];
    end
    ans.on_duty_id   = (ring_count != 0) ? ring_id[ring_head] : '0;
    ans.member_total = ring_count[TotalW-1:0];
    return ans;
  endfunction

  function automatic logic [IdW-1:0] member_at(int unsigned pos);
    logic [SlotW-1:0] slot;
    int unsigned      i;
    slot = ring_head;
    for (i = 0; i < pos; i++) slot = ring_link[slot];
    return ring_id[slot];
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("mismatch: %s", msg);
  endtask

  task automatic send_cmd(op_e op, logic [IdW-1:0] tgt);
    ring_answer_t ans;
    @(posedge clk_i);
    while (!calm_sender && $urandom_range(0, 99) < 27) @(posedge clk_i);
    start_i     <= 1'b1;
    operation_i <= op;
    target_id_i <= tgt;
    do @(posedge clk_i); while (busy_o);
    ans = ring_apply(op, tgt);
    pending_answers.push_back(ans);
    op_seen[op]++;
    status_seen[ans.status]++;
    // junk on the command fields between transfers
    start_i     <= 1'b0;
    operation_i <= 2'($urandom);
    target_id_i <= 16'($urandom);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    ring_answer_t exp;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no command outstanding");
      end else begin
        exp = pending_answers.pop_front();
        if (status_o !== exp.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, exp.status));
        if (result_id_o !== exp.result_id)
          report_mismatch($sformatf("result_id %0d, want %0d", result_id_o, exp.result_id));
        if (on_duty_id_o !== exp.on_duty_id)
          report_mismatch($sformatf("on_duty_id %0d, want %0d", on_duty_id_o,
                                    exp.on_duty_id));
        if (member_total_o !== exp.member_total)
          report_mismatch($sformatf("member_total %0d, want %0d", member_total_o,
                                    exp.member_total));
      end
    end
  end

  task automatic test_empty_ring();
    send_cmd(OpQuery, 16'h0000);
    send_cmd(OpRotate, 16'hFFFF);
    send_cmd(OpRemove, 16'h0000);
    send_cmd(OpRemove, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    repeat (Slots) send_cmd(OpAdd, 16'($urandom));
    send_cmd(OpAdd, 16'hFFFF);
    send_cmd(OpRotate, 16'h0000);
    wait_drained();
  endtask

  task automatic test_remove_positions();
    send_cmd(OpRemove, ring_id[ring_head]);
    send_cmd(OpRemove, ring_id[ring_tail]);
    send_cmd(OpRemove, member_at(3));
    send_cmd(OpRemove, 16'h0000);
    // freed slots are reused lowest first
    send_cmd(OpAdd, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned    k;
    int unsigned    roll;
    bit             fill_phase;
    op_e            op;
    logic [IdW-1:0] tgt;
    fill_phase = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) fill_phase = $urandom_range(0, 1);
      if (k % 150 == 149) wait_drained();
      calm_sender = (k >= 200 && k < 300);
      roll = $urandom_range(0, 99);
      tgt  = 16'($urandom);
      if (roll < (fill_phase ? 45 : 20)) begin
        op = OpAdd;
      end else if (roll < (fill_phase ? 65 : 60)) begin
        op = OpRemove;
        if (ring_count != 0) tgt = member_at($urandom_range(0, ring_count - 1));
      end else if (roll < 72) begin
        op = OpRemove;
      end else if (roll < 86) begin
        op = OpRotate;
      end else begin
        op = OpQuery;
      end
      send_cmd(op, tgt);
    end
    calm_sender = 1'b0;
    wait_drained();
  endtask

  initial begin
    ring_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring();
    test_fill_to_full();
    test_remove_positions();
    test_random_mix(600);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));

    $display("ran %0d add, %0d remove, %0d rotate, %0d query commands",
             op_seen[OpAdd], op_seen[OpRemove], op_seen[OpRotate], op_seen[OpQuery]);
    $display("answers: %0d ok, %0d empty, %0d not found, %0d full; id counter wrapped %0d",
             status_seen[StOk], status_seen[StEmpty], status_seen[StNotFound],
             status_seen[StFull], wrap_count);
    if (mismatch_count == 0) begin
      $display("** round_robin_ring_list_unit: PASSED **");
    end else begin
      $display("** round_robin_ring_list_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
